FILE: rtl/core/sqltok_pkg.sv
// Package for the SQL lexer token scanner: widths, token kinds, lexer modes,
// character constants and the structs passed between the scanner's modules.
// Depends on nothing; every other file of the block imports it.
package sqltok_pkg;

    localparam int MANT_W = 32;
    localparam int FRAC_W = 5;
    localparam int OFF_W  = 16;
    localparam int LINE_W = 16;
    localparam int CHAR_W = 8;
    localparam int KIND_W = 3;

    // Fraction digit count at which further digits stop entering the mantissa.
    localparam logic [FRAC_W-1:0] FRAC_MAX = {FRAC_W{1'b1}};

    // Result queue: deep enough to take two results while two more drain.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;

    typedef enum logic [KIND_W-1:0] {
        KIND_INT     = 3'd0,
        KIND_DECIMAL = 3'd1,
        KIND_WORD    = 3'd2,
        KIND_OPER    = 3'd3,
        KIND_BRACKET = 3'd4,
        KIND_PUNCT   = 3'd5,
        KIND_UNKNOWN = 3'd6,
        KIND_END     = 3'd7
    } kind_t;

    typedef enum logic [6:0] {
        MODE_IDLE = 7'b0000001,
        MODE_INT  = 7'b0000010,
        MODE_FRAC = 7'b0000100,
        MODE_WORD = 7'b0001000,
        MODE_OPER = 7'b0010000,
        MODE_ERR  = 7'b0100000,
        MODE_DONE = 7'b1000000
    } mode_t;

    typedef struct packed {
        logic digit;
        logic alpha;
        logic under;
        logic space;
        logic newline;
        logic oper;
        logic brack;
        logic punct;
    } class_t;

    typedef struct packed {
        kind_t             kind;
        logic [MANT_W-1:0] mantissa;
        logic [FRAC_W-1:0] frac_digits;
        logic [OFF_W-1:0]  start_offset;
        logic [OFF_W-1:0]  token_length;
        logic [LINE_W-1:0] line_no;
        logic [CHAR_W-1:0] single_char;
        logic              overflow;
        logic              last;
    } token_t;

    // Results of one byte, packed to the front: cnt says how many are valid.
    typedef struct packed {
        logic [1:0] cnt;
        token_t     tok0;
        token_t     tok1;
    } push_t;

endpackage

FILE: rtl/core/sqltok_classify.sv
// Character class decoder of the SQL lexer token scanner.
// Depends on sqltok_pkg for the class struct.
module sqltok_classify
    import sqltok_pkg::*;
(
    input  logic [CHAR_W-1:0] sym,
    output class_t            cls
);

    always_comb
    begin
        cls = '0;
        unique case (sym) inside
            [8'h30:8'h39]:                      cls.digit = 1'b1;
            [8'h41:8'h5A], [8'h61:8'h7A]:       cls.alpha = 1'b1;
            8'h5F:                              cls.under = 1'b1;
            8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D:  cls.space = 1'b1;
            8'h0A:
            begin
                cls.space   = 1'b1;
                cls.newline = 1'b1;
            end
            8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h5E,
            8'h21, 8'h3D, 8'h3C, 8'h3E:          cls.oper  = 1'b1;
            8'h28, 8'h29, 8'h7B, 8'h7D,
            8'h5B, 8'h5D:                       cls.brack = 1'b1;
            8'h3A, 8'h3B, 8'h2E, 8'h2C,
            8'h27, 8'h22:                       cls.punct = 1'b1;
            default:                            cls = '0;
        endcase
    end

endmodule

FILE: rtl/core/sqltok_core.sv
// Lexer state and token builder of the SQL lexer token scanner: one byte a
// cycle while step is high, up to two tokens a byte. Depends on sqltok_pkg.
module sqltok_core
    import sqltok_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [CHAR_W-1:0] sym,
    input  logic              end_of_input,
    input  class_t            cls,
    output push_t             push
);

    mode_t             mode_reg,  mode_next;
    logic [MANT_W-1:0] mant_reg,  mant_next;
    logic [FRAC_W-1:0] frac_reg,  frac_next;
    logic [OFF_W-1:0]  start_reg, start_next;
    logic [OFF_W-1:0]  len_reg,   len_next;
    logic [LINE_W-1:0] line_reg,  line_next;
    logic [OFF_W-1:0]  pos_reg,   pos_next;
    logic              sat_reg,   sat_next;

    logic              ended;
    logic              taken;
    logic [MANT_W+3:0] mant_sum;
    logic              mant_ovf;
    logic [MANT_W-1:0] mant_add;
    logic [OFF_W-1:0]  len_grow;
    logic              emit_a, emit_b;
    token_t            blank, tok_a, tok_b;

    assign ended = end_of_input | (sym == CHAR_NUL);

    // Times ten as two shifts and an add; a carry into the top bits means
    // the new digit no longer fits, so the mantissa sticks at all ones.
    assign mant_sum = ({4'b0, mant_reg} << 3) + ({4'b0, mant_reg} << 1)
                    + {{MANT_W{1'b0}}, sym[3:0]};
    assign mant_ovf = |mant_sum[MANT_W+3:MANT_W];
    assign mant_add = mant_ovf ? {MANT_W{1'b1}} : mant_sum[MANT_W-1:0];
    assign len_grow = (len_reg == {OFF_W{1'b1}}) ? len_reg : len_reg + 1'b1;

    always_comb
    begin
        blank         = '0;
        blank.line_no = line_reg;

        mode_next  = mode_reg;
        mant_next  = mant_reg;
        frac_next  = frac_reg;
        start_next = start_reg;
        len_next   = len_reg;
        line_next  = line_reg;
        sat_next   = sat_reg;
        pos_next   = pos_reg + 1'b1;
        taken      = 1'b0;
        emit_a     = 1'b0;
        emit_b     = 1'b0;
        tok_a      = blank;
        tok_b      = blank;

        // Pending token: extend it, or close it and hand the byte on.
        unique case (mode_reg) inside
            MODE_DONE:
            begin
                taken = 1'b1;
            end
            MODE_ERR:
            begin
                taken = 1'b1;
                if (ended)
                begin
                    emit_a             = 1'b1;
                    tok_a.kind         = KIND_END;
                    tok_a.start_offset = pos_reg;
                    mode_next          = MODE_DONE;
                end
            end
            MODE_INT, MODE_FRAC:
            begin
                if (!ended && cls.digit)
                begin
                    taken    = 1'b1;
                    len_next = len_grow;
                    if (mode_reg == MODE_FRAC)
                    begin
                        if (frac_reg != FRAC_MAX)
                        begin
                            mant_next = mant_add;
                            sat_next  = sat_reg | mant_ovf;
                            frac_next = frac_reg + 1'b1;
                        end
                        else
                        begin
                            sat_next = 1'b1;
                        end
                    end
                    else
                    begin
                        mant_next = mant_add;
                        sat_next  = sat_reg | mant_ovf;
                    end
                end
                else if (!ended && mode_reg == MODE_INT && sym == CHAR_POINT)
                begin
                    taken     = 1'b1;
                    len_next  = len_grow;
                    mode_next = MODE_FRAC;
                end
                else
                begin
                    emit_a             = 1'b1;
                    tok_a.kind         = (mode_reg == MODE_INT) ? KIND_INT : KIND_DECIMAL;
                    tok_a.mantissa     = mant_reg;
                    tok_a.frac_digits  = frac_reg;
                    tok_a.start_offset = start_reg;
                    tok_a.token_length = len_reg;
                    tok_a.overflow     = sat_reg;
                    mode_next          = MODE_IDLE;
                end
            end
            MODE_WORD:
            begin
                if (!ended && (cls.alpha || cls.digit || cls.under))
                begin
                    taken    = 1'b1;
                    len_next = len_grow;
                end
                else
                begin
                    emit_a             = 1'b1;
                    tok_a.kind         = KIND_WORD;
                    tok_a.start_offset = start_reg;
                    tok_a.token_length = len_reg;
                    mode_next          = MODE_IDLE;
                end
            end
            MODE_OPER:
            begin
                if (!ended && cls.oper)
                begin
                    taken    = 1'b1;
                    len_next = len_grow;
                end
                else
                begin
                    emit_a             = 1'b1;
                    tok_a.kind         = KIND_OPER;
                    tok_a.start_offset = start_reg;
                    tok_a.token_length = len_reg;
                    mode_next          = MODE_IDLE;
                end
            end
            MODE_IDLE:
            begin
                taken = 1'b0;
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        // Fresh byte: a space, a token start, a single-byte token, or the end.
        if (!taken)
        begin
            if (ended)
            begin
                emit_b             = 1'b1;
                tok_b.kind         = KIND_END;
                tok_b.start_offset = pos_reg;
                mode_next          = MODE_DONE;
            end
            else if (cls.space)
            begin
                if (cls.newline && line_reg != {LINE_W{1'b1}})
                begin
                    line_next = line_reg + 1'b1;
                end
            end
            else if (cls.digit || cls.alpha || cls.oper)
            begin
                start_next = pos_reg;
                len_next   = {{(OFF_W-1){1'b0}}, 1'b1};
                frac_next  = '0;
                sat_next   = 1'b0;
                mant_next  = '0;
                if (cls.digit)
                begin
                    mode_next = MODE_INT;
                    mant_next = {{(MANT_W-4){1'b0}}, sym[3:0]};
                end
                else if (cls.alpha)
                begin
                    mode_next = MODE_WORD;
                end
                else
                begin
                    mode_next = MODE_OPER;
                end
            end
            else
            begin
                emit_b             = 1'b1;
                tok_b.start_offset = pos_reg;
                tok_b.token_length = {{(OFF_W-1){1'b0}}, 1'b1};
                tok_b.single_char  = sym;
                if (cls.brack)
                begin
                    tok_b.kind = KIND_BRACKET;
                end
                else if (cls.punct)
                begin
                    tok_b.kind = KIND_PUNCT;
                end
                else
                begin
                    tok_b.kind = KIND_UNKNOWN;
                    mode_next  = MODE_ERR;
                end
            end
        end

        // Pack the results to the front of the push word.
        push.cnt       = step ? ({1'b0, emit_a} + {1'b0, emit_b}) : 2'd0;
        push.tok0      = emit_a ? tok_a : tok_b;
        push.tok0.last = !(emit_a && emit_b);
        push.tok1      = tok_b;
        push.tok1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            mant_reg  <= '0;
            frac_reg  <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            line_reg  <= {{(LINE_W-1){1'b0}}, 1'b1};
            pos_reg   <= '0;
            sat_reg   <= 1'b0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            mant_reg  <= mant_next;
            frac_reg  <= frac_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            line_reg  <= line_next;
            pos_reg   <= pos_next;
            sat_reg   <= sat_next;
        end
    end

endmodule

FILE: rtl/core/sqltok_outq.sv
// Result queue of the SQL lexer token scanner: takes up to two tokens a cycle
// and gives one a cycle to the output channel on pop. Depends on sqltok_pkg.
module sqltok_outq
    import sqltok_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  push_t              push,
    input  logic               pop,
    output token_t             head,
    output logic [Q_CNT_W-1:0] count
);

    token_t              mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]  count_reg,  count_next;
    logic [Q_PTR_W-1:0]  wr_ptr_inc;

    assign wr_ptr_inc  = wr_ptr_reg + 1'b1;
    assign wr_ptr_next = wr_ptr_reg + Q_PTR_W'(push.cnt);
    assign rd_ptr_next = rd_ptr_reg + Q_PTR_W'(pop);
    assign count_next  = count_reg + Q_CNT_W'(push.cnt) - Q_CNT_W'(pop);
    assign head        = mem[rd_ptr_reg];
    assign count       = count_reg;

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.tok0;
        end
        if (push.cnt == 2'd2)
        begin
            mem[wr_ptr_inc] <= push.tok1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/core/sql_lexer_token_scanner.sv
// Top level of the SQL lexer token scanner: input register, lexer core and
// result queue. Depends on sqltok_pkg, sqltok_classify, sqltok_core, sqltok_outq.
//
// Usage. Source text enters one byte per transfer on the input channel
// (in_valid, in_ready, sym, end_of_input); a zero byte or end_of_input ends
// the text. Token descriptors leave on the output channel (out_valid,
// out_ready and the token fields). A byte gives zero, one or two tokens: a
// multi-byte token is only closed by the first byte that cannot extend it,
// and that byte may itself be a single-byte token. The field last marks the
// final token caused by a byte.
// Order: the transfer loads the byte into the input register; a lexer step
// then writes its tokens into the result queue, whose head drives the output
// ports. The step waits while the queue lacks room for two tokens.
// Throughput: one byte per cycle while the lexer can step. The four-entry
// result queue decouples the sides; the lexer steps only while the queue has
// room for two tokens, so a stalled receiver back-pressures in_ready once the
// queue holds more than two tokens.
// Reset: rst_n clears the input valid flag, the queue and the lexer state
// (line one, offset zero, no token open). After the end token every further
// byte is taken and ignored until the next reset.
module sql_lexer_token_scanner
    import sqltok_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] sym,
    input  logic              end_of_input,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [KIND_W-1:0] token_kind,
    output logic [MANT_W-1:0] mantissa,
    output logic [FRAC_W-1:0] frac_digits,
    output logic [OFF_W-1:0]  start_offset,
    output logic [OFF_W-1:0]  token_length,
    output logic [LINE_W-1:0] line_no,
    output logic [CHAR_W-1:0] single_char,
    output logic              overflow,
    output logic              last
);

    logic               stage_valid_reg;
    logic [CHAR_W-1:0]  stage_sym_reg;
    logic               stage_eoi_reg;
    logic               in_xfer;
    logic               advance;
    class_t             cls;
    push_t              push;
    token_t             head;
    logic [Q_CNT_W-1:0] q_count;
    logic               pop;

    assign in_xfer  = in_valid && in_ready;
    // The lexer steps only when the queue can take a full pair of tokens.
    assign advance  = stage_valid_reg && (q_count <= Q_CNT_W'(Q_DEPTH - 2));
    assign in_ready = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    // Byte payload needs no reset; it is qualified by stage_valid_reg.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            stage_sym_reg <= sym;
            stage_eoi_reg <= end_of_input;
        end
    end

    sqltok_classify u_classify (
        .sym (stage_sym_reg),
        .cls (cls)
    );

    sqltok_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .sym          (stage_sym_reg),
        .end_of_input (stage_eoi_reg),
        .cls          (cls),
        .push         (push)
    );

    assign out_valid = (q_count != '0);
    assign pop       = out_valid && out_ready;

    sqltok_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .count (q_count)
    );

    assign token_kind   = head.kind;
    assign mantissa     = head.mantissa;
    assign frac_digits  = head.frac_digits;
    assign start_offset = head.start_offset;
    assign token_length = head.token_length;
    assign line_no      = head.line_no;
    assign single_char  = head.single_char;
    assign overflow     = head.overflow;
    assign last         = head.last;

    // The queue never holds more entries than it has.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue count beyond its depth");

    // A lexer step never pushes more tokens than the queue has free entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> ({1'b0, q_count} + (Q_CNT_W+1)'(push.cnt) <= (Q_CNT_W+1)'(Q_DEPTH)))
        else $error("lexer step would overrun the result queue");

    // A held byte stays in the input register, unchanged, until the lexer steps.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !advance) |=>
            (stage_valid_reg && $stable(stage_sym_reg) && $stable(stage_eoi_reg)))
        else $error("held byte lost or altered in the input register");

endmodule

FILE: tb/sv/sql_lexer_token_scanner_checker.sv
`timescale 1ns / 1ps
// Token checker for the SQL lexer token scanner: watches both channels, runs its own
// lexer on every byte transfer and compares each token transfer with the oldest expected one.
// Depends on sqltok_pkg for the field widths, the token kinds, the lexer modes and token_t.
module sql_lexer_token_scanner_checker
    import sqltok_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [CHAR_W-1:0] sym,
    input  logic              end_of_input,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [KIND_W-1:0] token_kind,
    input  logic [MANT_W-1:0] mantissa,
    input  logic [FRAC_W-1:0] frac_digits,
    input  logic [OFF_W-1:0]  start_offset,
    input  logic [OFF_W-1:0]  token_length,
    input  logic [LINE_W-1:0] line_no,
    input  logic [CHAR_W-1:0] single_char,
    input  logic              overflow,
    input  logic              last,
    output int                fail_count,
    output int                tokens_due
);

    localparam logic [MANT_W-1:0] MANT_MAX = {MANT_W{1'b1}};
    localparam logic [OFF_W-1:0]  LEN_MAX  = {OFF_W{1'b1}};
    localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;

    // Lexer state as the scanner should hold it.
    mode_t             lx_mode   = MODE_IDLE;
    logic [MANT_W-1:0] mant_acc  = '0;
    logic [FRAC_W-1:0] frac_cnt  = '0;
    logic [OFF_W-1:0]  tok_first = '0;
    logic [OFF_W-1:0]  tok_len   = '0;
    logic [LINE_W-1:0] line_cnt  = LINE_W'(1);
    logic [OFF_W-1:0]  byte_ofs  = '0;
    logic              sat_seen  = 1'b0;

    token_t due_q[$];
    int     errs = 0;

    function automatic bit is_digit(input logic [CHAR_W-1:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(input logic [CHAR_W-1:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_space(input logic [CHAR_W-1:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit is_oper(input logic [CHAR_W-1:0] c);
        case (c) inside
            "+", "-", "*", "/", "^", "!", "=", "<", ">": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit is_brack(input logic [CHAR_W-1:0] c);
        case (c) inside
            "(", ")", "{", "}", "[", "]": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit is_punct(input logic [CHAR_W-1:0] c);
        case (c) inside
            ":", ";", ".", ",", "'", "\"": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic token_t make_tok(input kind_t k, input logic [MANT_W-1:0] m,
                                        input logic [FRAC_W-1:0] f, input logic [OFF_W-1:0] s,
                                        input logic [OFF_W-1:0] len, input logic [CHAR_W-1:0] ch,
                                        input logic ovf);
        token_t t;
        t.kind         = k;
        t.mantissa     = m;
        t.frac_digits  = f;
        t.start_offset = s;
        t.token_length = len;
        t.line_no      = line_cnt;
        t.single_char  = ch;
        t.overflow     = ovf;
        t.last         = 1'b0;
        return t;
    endfunction

    // Multiply by ten and add, sticking at the top value once it would overflow.
    task automatic push_digit(input int d);
        longint unsigned wide;
        wide = mant_acc;
        if (wide > (longint'(MANT_MAX) - d) / 10)
        begin
            mant_acc = MANT_MAX;
            sat_seen = 1'b1;
        end
        else
        begin
            mant_acc = mant_acc * 10 + d;
        end
    endtask

    task automatic grow_len();
        if (tok_len != LEN_MAX)
            tok_len++;
    endtask

    task automatic open_token(input mode_t m);
        lx_mode   = m;
        tok_first = byte_ofs;
        tok_len   = OFF_W'(1);
        mant_acc  = '0;
        frac_cnt  = '0;
        sat_seen  = 1'b0;
    endtask

    // One byte through the lexer; the tokens it closes or makes are queued in order.
    task automatic lex_byte(input logic [CHAR_W-1:0] c, input logic eoi);
        token_t found [0:1];
        int     n;
        bit     consumed;
        bit     ended;
        n        = 0;
        consumed = 1'b0;
        ended    = eoi || c == CHAR_NUL;
        case (lx_mode) inside
            MODE_DONE:
                consumed = 1'b1;
            MODE_ERR:
            begin
                if (ended)
                begin
                    found[n] = make_tok(KIND_END, '0, '0, byte_ofs, '0, '0, 1'b0);
                    n++;
                    lx_mode = MODE_DONE;
                end
                consumed = 1'b1;
            end
            MODE_INT, MODE_FRAC:
            begin
                if (!ended && is_digit(c))
                begin
                    if (lx_mode == MODE_FRAC)
                    begin
                        if (frac_cnt != FRAC_MAX)
                        begin
                            push_digit(c - "0");
                            frac_cnt++;
                        end
                        else
                        begin
                            sat_seen = 1'b1;
                        end
                    end
                    else
                    begin
                        push_digit(c - "0");
                    end
                    grow_len();
                    consumed = 1'b1;
                end
                else if (!ended && lx_mode == MODE_INT && c == CHAR_POINT)
                begin
                    lx_mode = MODE_FRAC;
                    grow_len();
                    consumed = 1'b1;
                end
                else
                begin
                    if (lx_mode == MODE_INT)
                        found[n] = make_tok(KIND_INT, mant_acc, frac_cnt, tok_first, tok_len,
                                            '0, sat_seen);
                    else
                        found[n] = make_tok(KIND_DECIMAL, mant_acc, frac_cnt, tok_first, tok_len,
                                            '0, sat_seen);
                    n++;
                    lx_mode = MODE_IDLE;
                end
            end
            MODE_WORD:
            begin
                if (!ended && (is_alpha(c) || is_digit(c) || c == "_"))
                begin
                    grow_len();
                    consumed = 1'b1;
                end
                else
                begin
                    found[n] = make_tok(KIND_WORD, '0, '0, tok_first, tok_len, '0, 1'b0);
                    n++;
                    lx_mode = MODE_IDLE;
                end
            end
            MODE_OPER:
            begin
                if (!ended && is_oper(c))
                begin
                    grow_len();
                    consumed = 1'b1;
                end
                else
                begin
                    found[n] = make_tok(KIND_OPER, '0, '0, tok_first, tok_len, '0, 1'b0);
                    n++;
                    lx_mode = MODE_IDLE;
                end
            end
            default: ;
        endcase

        // A byte not absorbed by an open token starts afresh.
        if (!consumed)
        begin
            if (ended)
            begin
                found[n] = make_tok(KIND_END, '0, '0, byte_ofs, '0, '0, 1'b0);
                n++;
                lx_mode = MODE_DONE;
            end
            else if (is_space(c))
            begin
                if (c == CH_LF && line_cnt != LINE_MAX)
                    line_cnt++;
            end
            else if (is_digit(c))
            begin
                open_token(MODE_INT);
                mant_acc = c - "0";
            end
            else if (is_alpha(c))
            begin
                open_token(MODE_WORD);
            end
            else if (is_oper(c))
            begin
                open_token(MODE_OPER);
            end
            else if (is_brack(c))
            begin
                found[n] = make_tok(KIND_BRACKET, '0, '0, byte_ofs, OFF_W'(1), c, 1'b0);
                n++;
            end
            else if (is_punct(c))
            begin
                found[n] = make_tok(KIND_PUNCT, '0, '0, byte_ofs, OFF_W'(1), c, 1'b0);
                n++;
            end
            else
            begin
                found[n] = make_tok(KIND_UNKNOWN, '0, '0, byte_ofs, OFF_W'(1), c, 1'b0);
                n++;
                lx_mode = MODE_ERR;
            end
        end

        byte_ofs++;
        if (n > 0)
            found[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            due_q = {due_q, found[i]};
    endtask

    task automatic match_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errs++;
        end
    endtask

    task automatic compare_token();
        token_t want;
        if (due_q.size() == 0)
        begin
            $error("token transfer with nothing expected: kind %0d at offset %0d",
                   token_kind, start_offset);
            errs++;
        end
        else
        begin
            want = due_q.pop_front();
            match_field("token_kind", want.kind, token_kind);
            match_field("mantissa", want.mantissa, mantissa);
            match_field("frac_digits", want.frac_digits, frac_digits);
            match_field("start_offset", want.start_offset, start_offset);
            match_field("token_length", want.token_length, token_length);
            match_field("line_no", want.line_no, line_no);
            match_field("single_char", want.single_char, single_char);
            match_field("overflow", want.overflow, overflow);
            match_field("last", want.last, last);
        end
    endtask

    // Outputs are compared before the byte of the same edge is lexed, so a token can
    // never be matched against an expectation made at the edge it appears on.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lx_mode   = MODE_IDLE;
            mant_acc  = '0;
            frac_cnt  = '0;
            tok_first = '0;
            tok_len   = '0;
            line_cnt  = LINE_W'(1);
            byte_ofs  = '0;
            sat_seen  = 1'b0;
            due_q.delete();
            errs      = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                compare_token();
            if (in_valid && in_ready)
                lex_byte(sym, end_of_input);
        end
        fail_count <= errs;
        tokens_due <= due_q.size();
    end

endmodule

FILE: tb/sv/sql_lexer_token_scanner_tb.sv
`timescale 1ns / 1ps
// Top of the SQL lexer token scanner testbench: clock, reset, byte stimulus, receiver
// and verdict. Depends on sqltok_pkg, the scanner RTL and sql_lexer_token_scanner_checker.
module sql_lexer_token_scanner_tb;
    import sqltok_pkg::*;

    // The scanner takes one byte per cycle while its result queue has room, and the
    // wait after the last expectation is met gives stray tokens time to show.
    localparam int DRAIN_CYCLES    = 10;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int HOLD_OFF_CYCLES = 300;

    localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;

    logic              clk;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic [CHAR_W-1:0] sym          = '0;
    logic              end_of_input = 1'b0;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic [KIND_W-1:0] token_kind;
    logic [MANT_W-1:0] mantissa;
    logic [FRAC_W-1:0] frac_digits;
    logic [OFF_W-1:0]  start_offset;
    logic [OFF_W-1:0]  token_length;
    logic [LINE_W-1:0] line_no;
    logic [CHAR_W-1:0] single_char;
    logic              overflow;
    logic              last;

    int fail_count;
    int tokens_due;

    // Idling controls shared between the stimulus and the receiver. A maximum of zero
    // gives a stretch with no idling on that side.
    int tx_gap_max    = 12;
    int rx_gap_max    = 12;
    bit hold_off_req  = 1'b0;
    int bytes_sent    = 0;

    sql_lexer_token_scanner uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sym          (sym),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .mantissa     (mantissa),
        .frac_digits  (frac_digits),
        .start_offset (start_offset),
        .token_length (token_length),
        .line_no      (line_no),
        .single_char  (single_char),
        .overflow     (overflow),
        .last         (last)
    );

    sql_lexer_token_scanner_checker token_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sym          (sym),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .mantissa     (mantissa),
        .frac_digits  (frac_digits),
        .start_offset (start_offset),
        .token_length (token_length),
        .line_no      (line_no),
        .single_char  (single_char),
        .overflow     (overflow),
        .last         (last),
        .fail_count   (fail_count),
        .tokens_due   (tokens_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Byte pickers. All but pick_low_unknown give bytes that cannot throw the lexer
    // into its error state; unknown symbols are only sent at the very end of the
    // text, since everything after one is ignored and reset is never applied again.
    function automatic logic [CHAR_W-1:0] pick_digit();
        return CHAR_W'(8'h30 + $urandom_range(0, 9));
    endfunction

    function automatic logic [CHAR_W-1:0] pick_letter();
        return CHAR_W'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + $urandom_range(0, 25));
    endfunction

    function automatic logic [CHAR_W-1:0] pick_word_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return pick_letter();
        else if (r < 9)
            return pick_digit();
        else
            return "_";
    endfunction

    function automatic logic [CHAR_W-1:0] pick_oper();
        case ($urandom_range(0, 8))
            0: return "+";
            1: return "-";
            2: return "*";
            3: return "/";
            4: return "^";
            5: return "!";
            6: return "=";
            7: return "<";
            default: return ">";
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] pick_bracket();
        case ($urandom_range(0, 5))
            0: return "(";
            1: return ")";
            2: return "{";
            3: return "}";
            4: return "[";
            default: return "]";
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] pick_punct();
        case ($urandom_range(0, 5))
            0: return ":";
            1: return ";";
            2: return ".";
            3: return ",";
            4: return "'";
            default: return "\"";
        endcase
    endfunction

    // Space, tab, line feed, vertical tab, form feed or carriage return.
    function automatic logic [CHAR_W-1:0] pick_space();
        case ($urandom_range(0, 5))
            0: return 8'h20;
            1: return 8'h09;
            2: return CH_LF;
            3: return 8'h0B;
            4: return 8'h0C;
            default: return 8'h0D;
        endcase
    endfunction

    // Low bytes that start no token: unknown symbols when no token is open.
    function automatic logic [CHAR_W-1:0] pick_low_unknown();
        case ($urandom_range(0, 5))
            0: return "#";
            1: return "_";
            2: return "@";
            3: return "?";
            4: return 8'h7F;
            default: return CHAR_W'($urandom_range(1, 8));
        endcase
    endfunction

    // One byte transfer on the input channel. The gap is drawn first; valid is only
    // dropped when there is a gap, so back-to-back bytes keep it high without a glitch,
    // and it is never lowered and raised within the same time step.
    task automatic send_byte(input logic [CHAR_W-1:0] c, input logic eoi);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        sym          <= c;
        end_of_input <= eoi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    task automatic send_digits(input int n);
        repeat (n) send_byte(pick_digit(), 1'b0);
    endtask

    // A well-formed token with random content, followed by whitespace most of the
    // time. Without a separator the next token abuts this one, which is what makes a
    // single byte close one token and emit another, and sometimes merges the two.
    task automatic send_random_token();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            // Integers: mostly short, now and then long enough to saturate.
            send_digits(($urandom_range(0, 7) == 0) ? $urandom_range(10, 14)
                                                    : $urandom_range(1, 4));
        end
        else if (pick < 36)
        begin
            // Decimals: a point with no digits after it still makes a decimal; long
            // fractions may pass the digit limit, long integer parts may saturate.
            send_digits(($urandom_range(0, 7) == 0) ? $urandom_range(8, 12)
                                                    : $urandom_range(1, 3));
            send_byte(CHAR_POINT, 1'b0);
            send_digits(($urandom_range(0, 7) == 0) ? $urandom_range(29, 35)
                                                    : $urandom_range(0, 4));
        end
        else if (pick < 56)
        begin
            send_byte(pick_letter(), 1'b0);
            repeat ($urandom_range(0, 6)) send_byte(pick_word_char(), 1'b0);
        end
        else if (pick < 68)
        begin
            repeat ($urandom_range(1, 3)) send_byte(pick_oper(), 1'b0);
        end
        else if (pick < 79)
        begin
            send_byte(pick_bracket(), 1'b0);
        end
        else if (pick < 90)
        begin
            send_byte(pick_punct(), 1'b0);
        end
        else
        begin
            // Loose bytes from every legal class in any order.
            repeat ($urandom_range(1, 3))
            begin
                case ($urandom_range(0, 5))
                    0: send_byte(pick_digit(), 1'b0);
                    1: send_byte(pick_letter(), 1'b0);
                    2: send_byte(pick_oper(), 1'b0);
                    3: send_byte(pick_bracket(), 1'b0);
                    4: send_byte(pick_punct(), 1'b0);
                    default: send_byte(pick_space(), 1'b0);
                endcase
            end
        end
        if ($urandom_range(0, 9) < 6)
            send_byte(pick_space(), 1'b0);
    endtask

    // Receiver. Each token draws its own stall; when asked, it also holds off for a
    // long stretch so that the result queue fills and in_ready falls while the sender
    // keeps offering bytes.
    initial
    begin : rx_side
        int stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            stall = $urandom_range(0, rx_gap_max);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("sql_lexer_token_scanner_tb NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: a word with an underscore and a digit, a decimal, a
        // decimal ending in a bare point, an operator run, brackets and every
        // punctuation mark but the point, with tab and newline as separators.
        send_text("x_1 42.5 7.;(<=)\t\n{}[],:'\"");

        // Random text with idling on both sides.
        while (bytes_sent < 250)
            send_random_token();

        // A stretch with no idling at all.
        tx_gap_max = 0;
        rx_gap_max = 0;
        while (bytes_sent < 330)
            send_random_token();

        // Back-pressure: the receiver stops for a long stretch while bytes keep coming.
        rx_gap_max   = 3;
        hold_off_req = 1'b1;
        while (hold_off_req || bytes_sent < 400)
            send_random_token();

        // Lopsided idling, first the sender slow, then the receiver.
        tx_gap_max = 12;
        rx_gap_max = 0;
        while (bytes_sent < 450)
            send_random_token();
        tx_gap_max = 0;
        rx_gap_max = 12;
        while (bytes_sent < 500)
            send_random_token();

        tx_gap_max = 12;
        rx_gap_max = 12;
        repeat (8) send_random_token();

        // End of text. Either an unknown symbol puts the lexer in its error state,
        // the following bytes are ignored and the end flag brings the end token; or a
        // zero byte closes a pending decimal and ends the text in the same byte.
        if ($urandom_range(0, 1))
        begin
            send_byte($urandom_range(0, 1) ? CHAR_W'($urandom_range(128, 255))
                                           : pick_low_unknown(), 1'b0);
            repeat (8) send_byte(CHAR_W'($urandom_range(1, 255)), 1'b0);
            send_byte(CHAR_W'($urandom_range(0, 255)), 1'b1);
        end
        else
        begin
            send_digits($urandom_range(1, 3));
            send_byte(CHAR_POINT, 1'b0);
            send_digits($urandom_range(0, 2));
            send_byte(CHAR_NUL, 1'b0);
        end

        // After the end token every byte is taken and ignored.
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(CHAR_NUL, 1'b0);
        repeat (6) send_byte(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        in_valid <= 1'b0;

        while (tokens_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && tokens_due == 0)
            $display("sql_lexer_token_scanner_tb OK");
        else
            $display("sql_lexer_token_scanner_tb NOT OK");
        $finish;
    end

endmodule
